### sv/scc_pkg.sv
// Package with opcodes, status codes and the slot record type of the sector cache controller.
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;
  localparam logic [2:0] OP_ACQUIRE = 3'd0;
  localparam logic [2:0] OP_PROBE = 3'd1;
  localparam logic [2:0] OP_LOAD_DONE = 3'd2;
  localparam logic [2:0] OP_REL_READ = 3'd3;
  localparam logic [2:0] OP_REL_WRITE = 3'd4;
  localparam logic [2:0] OP_WRITE_BEHIND = 3'd5;
  localparam logic [2:0] OP_FLUSH = 3'd6;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_MISS = 3'd1;
  localparam logic [2:0] ST_BUSY = 3'd2;
  localparam logic [2:0] ST_PROBE_MISS = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_ACK = 3'd5;

  localparam logic [7:0] PIN_MAX = 8'd255;

  typedef struct packed {
    logic        dirty;
    logic        accessed;
    logic        loaded;
    logic [7:0]  pins;
  } meta_t;
endpackage
`default_nettype wire

### sv/sector_cache_clock_controller_core.sv
// Top level of the sector cache controller: sequencer over tag and metadata memories.
//
// Channel   Direction  Ports
// request   in         start, busy, opcode, sector, slot_in
// result    out        strobe, status, slot, write_back, write_sector, read_needed, last
//
// A request is taken when start is high and busy is low; busy stays high until the cycle
// in which the last result is shown, and an unused opcode answers in the next cycle
// without raising busy. Each slot visit has a read state, then a check and write-back
// state, in lookup, flush and clock sweep passes alike. After reset a clearing pass
// zeroes the metadata memory while busy is high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module sector_cache_clock_controller_core
  import scc_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [31:0] sector,
  input  wire logic [5:0]  slot_in,
  output logic             strobe,
  output logic [2:0]       status,
  output logic [5:0]       slot,
  output logic             write_back,
  output logic [31:0]      write_sector,
  output logic             read_needed,
  output logic             last
);
  localparam int AW = $clog2(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam int SW = $clog2(2 * SLOTS + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK_RD, S_LOOK_CK, S_SWEEP_RD, S_SWEEP_CK,
    S_FL_RD, S_FL_CK, S_FL_END, S_SINGLE_RD, S_SINGLE_CK
  } state_t;

  state_t state;
  logic [2:0] op;
  logic [31:0] sec;
  logic [5:0] sin;
  logic [AW-1:0] idx;
  logic [AW-1:0] hand;
  logic [SW-1:0] steps;
  logic [SLOTS-1:0] valid;
  logic free_found;
  logic [AW-1:0] free_idx;
  logic pend;
  logic [AW-1:0] pend_slot;
  logic [31:0] pend_sec;

  logic t_we, m_we;
  logic [AW-1:0] t_waddr, m_waddr, raddr;
  logic [31:0] t_wdata, t_rdata;
  meta_t m_wdata, m_rdata;

  scc_tag_mem #(.SLOTS(SLOTS)) u_tag (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(raddr), .rdata(t_rdata)
  );
  scc_meta_mem #(.SLOTS(SLOTS)) u_meta (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(raddr), .rdata(m_rdata)
  );

  logic in_range;
  logic sin_ok;
  assign in_range = {26'd0, sin} < 32'(SLOTS);
  assign sin_ok = in_range && valid[sin[AW-1:0]];
  logic [AW-1:0] hand_inc;
  assign hand_inc = (hand == LAST_SLOT) ? '0 : hand + AW'(1);

  always_comb begin
    raddr = idx;
    if (state == S_SWEEP_RD) begin
      raddr = hand;
    end else if (state == S_SINGLE_RD) begin
      raddr = sin[AW-1:0];
    end
  end

  always_comb begin
    t_we = 1'b0;
    m_we = 1'b0;
    t_waddr = idx;
    m_waddr = idx;
    t_wdata = sec;
    m_wdata = m_rdata;
    unique case (state)
      S_CLEAR: begin
        m_we = 1'b1;
        m_wdata = '0;
      end
      S_LOOK_CK: begin
        if (idx == LAST_SLOT || (valid[idx] && t_rdata == sec)) begin
          if (valid[idx] && t_rdata == sec) begin
            if (op == OP_ACQUIRE) begin
              m_we = 1'b1;
              if (m_rdata.pins != PIN_MAX) begin
                m_wdata.pins = m_rdata.pins + 8'd1;
              end
            end
          end else if (op == OP_ACQUIRE && (free_found || !valid[idx])) begin
            t_we = 1'b1;
            m_we = 1'b1;
            t_waddr = free_found ? free_idx : idx;
            m_waddr = free_found ? free_idx : idx;
            m_wdata = '{dirty: 1'b0, accessed: 1'b1, loaded: 1'b0, pins: 8'd1};
          end
        end
      end
      S_SWEEP_CK: begin
        m_waddr = hand;
        t_waddr = hand;
        if (m_rdata.pins == 8'd0) begin
          m_we = 1'b1;
          if (m_rdata.accessed) begin
            m_wdata.accessed = 1'b0;
          end else begin
            t_we = 1'b1;
            m_wdata = '{dirty: 1'b0, accessed: 1'b1, loaded: 1'b0, pins: 8'd1};
          end
        end
      end
      S_FL_CK: begin
        if (valid[idx] && m_rdata.dirty && (op == OP_FLUSH || m_rdata.loaded)) begin
          m_we = 1'b1;
          m_wdata.dirty = 1'b0;
        end
      end
      S_SINGLE_CK: begin
        m_waddr = sin[AW-1:0];
        if (sin_ok) begin
          m_we = 1'b1;
          if (op == OP_LOAD_DONE) begin
            m_wdata.loaded = 1'b1;
          end else begin
            m_wdata.accessed = 1'b1;
            if (op == OP_REL_WRITE) begin
              m_wdata.dirty = 1'b1;
            end
            if (m_rdata.pins != 8'd0) begin
              m_wdata.pins = m_rdata.pins - 8'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      hand <= LAST_SLOT;
      valid <= '0;
      busy <= 1'b1;
      strobe <= 1'b0;
      pend <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          strobe <= 1'b0;
          idx <= (idx == LAST_SLOT) ? '0 : idx + AW'(1);
          if (idx == LAST_SLOT) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        S_IDLE: begin
          strobe <= start && opcode == OP_UNUSED;
          if (start) begin
            busy <= (opcode != OP_UNUSED);
            op <= opcode;
            sec <= sector;
            sin <= slot_in;
            idx <= '0;
            free_found <= 1'b0;
            pend <= 1'b0;
            steps <= '0;
            if (opcode == OP_ACQUIRE || opcode == OP_PROBE) begin
              state <= S_LOOK_RD;
            end else if (opcode == OP_WRITE_BEHIND || opcode == OP_FLUSH) begin
              state <= S_FL_RD;
            end else if (opcode == OP_UNUSED) begin
              status <= ST_ACK;
              slot <= '0;
              write_back <= 1'b0;
              write_sector <= '0;
              read_needed <= 1'b0;
              last <= 1'b1;
            end else begin
              state <= S_SINGLE_RD;
            end
          end
        end
        S_LOOK_RD: begin
          strobe <= 1'b0;
          state <= S_LOOK_CK;
        end
        S_LOOK_CK: begin
          write_back <= 1'b0;
          write_sector <= '0;
          last <= 1'b1;
          if (valid[idx] && t_rdata == sec) begin
            strobe <= 1'b1;
            status <= ST_HIT;
            slot <= 6'(idx);
            read_needed <= 1'b0;
            busy <= 1'b0;
            state <= S_IDLE;
          end else if (idx != LAST_SLOT) begin
            strobe <= 1'b0;
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx <= idx;
            end
            idx <= idx + AW'(1);
            state <= S_LOOK_RD;
          end else if (op == OP_PROBE) begin
            strobe <= 1'b1;
            status <= ST_PROBE_MISS;
            slot <= '0;
            read_needed <= 1'b0;
            busy <= 1'b0;
            state <= S_IDLE;
          end else if (free_found || !valid[idx]) begin
            strobe <= 1'b1;
            status <= ST_MISS;
            slot <= free_found ? 6'(free_idx) : 6'(idx);
            read_needed <= 1'b1;
            valid[free_found ? free_idx : idx] <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            hand <= hand_inc;
            state <= S_SWEEP_RD;
          end
        end
        S_SWEEP_RD: begin
          strobe <= 1'b0;
          state <= S_SWEEP_CK;
        end
        S_SWEEP_CK: begin
          if (m_rdata.pins == 8'd0 && !m_rdata.accessed) begin
            strobe <= 1'b1;
            status <= ST_MISS;
            slot <= 6'(hand);
            write_back <= 1'b1;
            write_sector <= t_rdata;
            read_needed <= 1'b1;
            last <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else if (steps == SW'(2 * SLOTS - 1)) begin
            strobe <= 1'b1;
            status <= ST_BUSY;
            slot <= '0;
            write_back <= 1'b0;
            write_sector <= '0;
            read_needed <= 1'b0;
            last <= 1'b1;
            busy <= 1'b0;
            state <= S_IDLE;
          end else begin
            strobe <= 1'b0;
            steps <= steps + SW'(1);
            hand <= hand_inc;
            state <= S_SWEEP_RD;
          end
        end
        S_FL_RD: begin
          strobe <= 1'b0;
          state <= S_FL_CK;
        end
        S_FL_CK: begin
          if (valid[idx] && m_rdata.dirty && (op == OP_FLUSH || m_rdata.loaded)) begin
            strobe <= pend;
            if (pend) begin
              status <= ST_FLUSH;
              slot <= 6'(pend_slot);
              write_back <= 1'b1;
              write_sector <= pend_sec;
              read_needed <= 1'b0;
              last <= 1'b0;
            end
            pend <= 1'b1;
            pend_slot <= idx;
            pend_sec <= t_rdata;
          end else begin
            strobe <= 1'b0;
          end
          if (idx == LAST_SLOT) begin
            state <= S_FL_END;
          end else begin
            idx <= idx + AW'(1);
            state <= S_FL_RD;
          end
        end
        S_FL_END: begin
          strobe <= 1'b1;
          status <= pend ? ST_FLUSH : ST_ACK;
          slot <= pend ? 6'(pend_slot) : '0;
          write_back <= pend;
          write_sector <= pend ? pend_sec : '0;
          read_needed <= 1'b0;
          last <= 1'b1;
          busy <= 1'b0;
          pend <= 1'b0;
          state <= S_IDLE;
        end
        S_SINGLE_RD: begin
          strobe <= 1'b0;
          state <= S_SINGLE_CK;
        end
        S_SINGLE_CK: begin
          strobe <= 1'b1;
          status <= ST_ACK;
          slot <= sin_ok ? sin : '0;
          write_back <= 1'b0;
          write_sector <= '0;
          read_needed <= 1'b0;
          last <= 1'b1;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: begin
          strobe <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !strobe)
    else $error("result shown during clearing pass");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final result shown while busy is high");
  a_wb_sector: assert property (@(posedge clk) disable iff (rst)
    (strobe && !write_back) |-> (write_sector == 32'd0))
    else $error("write sector set without write-back");
`endif
endmodule
`default_nettype wire

### sv/scc_tag_mem.sv
// Synchronous tag memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scc_tag_mem #(
  parameter int SLOTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(SLOTS)-1:0] waddr,
  input  wire logic [31:0]              wdata,
  input  wire logic [$clog2(SLOTS)-1:0] raddr,
  output logic [31:0]                   rdata
);
  logic [31:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### sv/scc_meta_mem.sv
// Synchronous slot metadata memory with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scc_meta_mem
  import scc_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(SLOTS)-1:0] waddr,
  input  wire meta_t                    wdata,
  input  wire logic [$clog2(SLOTS)-1:0] raddr,
  output meta_t                         rdata
);
  meta_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
